[rtl/udrq_pkg.sv]
// Shared types, constants and helpers for the dual UART ring queue.
`timescale 1ns / 1ps

package udrq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       stored;
    logic       send_irq_on;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // Advance a queue pointer with wrap at the queue depth.
  function automatic ptr_t next_ptr(input ptr_t p);
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

endpackage

[rtl/udrq_ctrl.sv]
// Controller state machine: sequences load, execute and result strobe.
`timescale 1ns / 1ps

module udrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output udrq_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == ST_EXEC);
  assign out_valid = (state_r == ST_DONE);

endmodule

[rtl/udrq_datapath.sv]
// Datapath: both byte queues, their pointers, interrupt flags and result registers.
`timescale 1ns / 1ps

module udrq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  udrq_pkg::dp_cmd_t   cmd,
  input  udrq_pkg::in_item_t  in_item,
  output udrq_pkg::out_item_t out_item
);

  udrq_pkg::in_item_t item_r;

  logic [7:0] rx_mem [udrq_pkg::QUEUE_DEPTH];
  logic [7:0] tx_mem [udrq_pkg::QUEUE_DEPTH];
  logic [7:0] rx_q_r;
  logic [7:0] tx_q_r;

  udrq_pkg::ptr_t rx_wptr_r, rx_wptr_nxt;
  udrq_pkg::ptr_t rx_rptr_r, rx_rptr_nxt;
  udrq_pkg::ptr_t tx_wptr_r, tx_wptr_nxt;
  udrq_pkg::ptr_t tx_rptr_r, tx_rptr_nxt;

  logic irq_r, irq_nxt;
  logic disc_r, disc_nxt;
  logic read_valid_r, read_valid_nxt;
  logic send_valid_r, send_valid_nxt;
  logic stored_r, stored_nxt;

  logic rx_we, rx_re, tx_we, tx_re;
  logic rx_full, rx_empty, tx_full, tx_empty;

  assign rx_full  = (udrq_pkg::next_ptr(rx_wptr_r) == rx_rptr_r);
  assign tx_full  = (udrq_pkg::next_ptr(tx_wptr_r) == tx_rptr_r);
  assign rx_empty = (rx_wptr_r == rx_rptr_r);
  assign tx_empty = (tx_wptr_r == tx_rptr_r);

  always_comb begin
    rx_wptr_nxt    = rx_wptr_r;
    rx_rptr_nxt    = rx_rptr_r;
    tx_wptr_nxt    = tx_wptr_r;
    tx_rptr_nxt    = tx_rptr_r;
    irq_nxt        = irq_r;
    disc_nxt       = disc_r;
    read_valid_nxt = read_valid_r;
    send_valid_nxt = send_valid_r;
    stored_nxt     = stored_r;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    if (cmd.exec) begin
      read_valid_nxt = 1'b0;
      send_valid_nxt = 1'b0;
      stored_nxt     = 1'b0;
      unique case (item_r.op)
        udrq_pkg::OP_PUT: begin
          if (!disc_r) begin
            if (tx_full) begin
              // A refused byte drops the rest of its string.
              disc_nxt = 1'b1;
              irq_nxt  = 1'b1;
            end else begin
              tx_we       = 1'b1;
              tx_wptr_nxt = udrq_pkg::next_ptr(tx_wptr_r);
              stored_nxt  = 1'b1;
            end
          end
          if (item_r.string_last) begin
            disc_nxt = 1'b0;
            irq_nxt  = 1'b1;
          end
        end
        udrq_pkg::OP_GET: begin
          if (!rx_empty) begin
            rx_re          = 1'b1;
            rx_rptr_nxt    = udrq_pkg::next_ptr(rx_rptr_r);
            read_valid_nxt = 1'b1;
          end
        end
        udrq_pkg::OP_RECV: begin
          if (!rx_full) begin
            rx_we       = 1'b1;
            rx_wptr_nxt = udrq_pkg::next_ptr(rx_wptr_r);
            stored_nxt  = 1'b1;
          end
        end
        udrq_pkg::OP_TICK: begin
          if (irq_r) begin
            if (!tx_empty) begin
              tx_re          = 1'b1;
              tx_rptr_nxt    = udrq_pkg::next_ptr(tx_rptr_r);
              send_valid_nxt = 1'b1;
            end else begin
              irq_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wptr_r    <= '0;
      rx_rptr_r    <= '0;
      tx_wptr_r    <= '0;
      tx_rptr_r    <= '0;
      irq_r        <= 1'b0;
      disc_r       <= 1'b0;
      read_valid_r <= 1'b0;
      send_valid_r <= 1'b0;
      stored_r     <= 1'b0;
    end else begin
      rx_wptr_r    <= rx_wptr_nxt;
      rx_rptr_r    <= rx_rptr_nxt;
      tx_wptr_r    <= tx_wptr_nxt;
      tx_rptr_r    <= tx_rptr_nxt;
      irq_r        <= irq_nxt;
      disc_r       <= disc_nxt;
      read_valid_r <= read_valid_nxt;
      send_valid_r <= send_valid_nxt;
      stored_r     <= stored_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wptr_r] <= item_r.data_byte;
    end
    if (rx_re) begin
      rx_q_r <= rx_mem[rx_rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wptr_r] <= item_r.data_byte;
    end
    if (tx_re) begin
      tx_q_r <= tx_mem[tx_rptr_r];
    end
  end

  assign out_item.read_byte   = read_valid_r ? rx_q_r : 8'd0;
  assign out_item.read_valid  = read_valid_r;
  assign out_item.send_valid  = send_valid_r;
  assign out_item.send_byte   = send_valid_r ? tx_q_r : 8'd0;
  assign out_item.stored      = stored_r;
  assign out_item.send_irq_on = irq_r;

endmodule

[rtl/uart_dual_ring_queue_core.sv]
// Top level of the dual UART ring queue: controller plus datapath.
`timescale 1ns / 1ps

// Two circular byte queues between software and a UART. Each item carries an
// operation: put a transmit byte (with a string-last mark), get a received
// byte, store a byte from the receiver, or a transmitter-ready tick.
// An item is taken at a rising edge with start high and busy low. busy is
// high for the one cycle in which the item executes against the queues.
// Every item gives exactly one result, shown on out_item for one cycle with
// out_valid high (state ST_DONE, after the execute state ST_EXEC); the receiver must
// take it then, as there is no back pressure.
// The queue memories have a registered read port, so each item passes
// through an execute state for the memory access and a done state that
// shows the result; no item is taken during execution. A new item may be
// taken in the cycle in which the previous result is shown.
// Reset (rst_n low, synchronous) empties both queues, clears the pointers,
// the transmit interrupt enable and the string-abort flag; no clearing pass.
module uart_dual_ring_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  udrq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output udrq_pkg::out_item_t out_item
);

  udrq_pkg::dp_cmd_t cmd;

  udrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  udrq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // An accepted item executes in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && cmd.exec))
    else $error("accepted item did not execute");

  // Execution is always followed by exactly one result strobe.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execution not followed by a result");

  // A get never also stores or sends.
  a_get_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.read_valid) |-> (!out_item.send_valid && !out_item.stored))
    else $error("get result mixed with other flags");

  // A sent byte implies the interrupt was still on.
  a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.send_valid) |-> out_item.send_irq_on)
    else $error("byte sent with interrupt off");

endmodule
